// ===== sv/els_pkg.sv =====
package els_pkg;

   // Event codes carried in the cmd field
   localparam logic [2:0] CMD_TICK      = 3'd0;
   localparam logic [2:0] CMD_POWER_ON  = 3'd1;
   localparam logic [2:0] CMD_POWER_OFF = 3'd2;
   localparam logic [2:0] CMD_COMM      = 3'd3;
   localparam logic [2:0] CMD_LATCH     = 3'd4;
   localparam logic [2:0] CMD_CLEAR     = 3'd5;
   localparam logic [2:0] CMD_RESET     = 3'd6;

   // Register indexes of the CSR port
   localparam logic [1:0] CSR_POWER_ON_DELAY  = 2'd0;
   localparam logic [1:0] CSR_COMM_TIMEOUT    = 2'd1;
   localparam logic [1:0] CSR_RECOVERY_DELAY  = 2'd2;
   localparam logic [1:0] CSR_PERIODIC_PERIOD = 2'd3;

   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = 32;

   // Register reset values
   localparam logic [31:0] POWER_ON_DELAY_RST  = 32'd100;
   localparam logic [31:0] COMM_TIMEOUT_RST    = 32'd500;
   localparam logic [31:0] RECOVERY_DELAY_RST  = 32'd1000;
   localparam logic [31:0] PERIODIC_PERIOD_RST = 32'd10;

   // Fixed dwell times in milliseconds
   localparam logic [31:0] SELF_TEST_DWELL = 32'd60;
   localparam logic [31:0] SETTLE_DWELL    = 32'd100;

   localparam logic [15:0] ATTEMPT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  cmd;
      logic        fault_present;
      logic [31:0] now_ms;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic        mode_changed;
      logic        periodic_fire;
      logic        safe_outputs;
      logic        comm_fault_flag;
      logic        latched_flag;
      logic        powered;
      logic [15:0] attempts;
   } rsp_item_type;

endpackage

// ===== sv/els_if.sv =====
interface els_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic        fault_present;
   logic [31:0] now_ms;

   modport source (output valid, cmd, fault_present, now_ms, input ready);
   modport sink (input valid, cmd, fault_present, now_ms, output ready);
endinterface

interface els_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic        mode_changed;
   logic        periodic_fire;
   logic        safe_outputs;
   logic        comm_fault_flag;
   logic        latched_flag;
   logic        powered;
   logic [15:0] attempts;

   modport source (output valid, mode, mode_changed, periodic_fire, safe_outputs,
                   comm_fault_flag, latched_flag, powered, attempts, input ready);
   modport sink (input valid, mode, mode_changed, periodic_fire, safe_outputs,
                 comm_fault_flag, latched_flag, powered, attempts, output ready);
endinterface

// ===== sv/ecu_lifecycle_supervisor_top.sv =====
// Controller lifecycle supervisor.
// req_bus carries one event per item: cmd, fault_present and a millisecond
// timestamp now_ms. rsp_bus returns exactly one item per event: the mode after
// the event, change/periodic/safe indications, the fault flags, power request
// and the saturating recovery attempt count.
// The csr_ port writes the four 32-bit timing registers (power-on delay, comm
// timeout, recovery delay, periodic period); write only while no event is in
// flight.
// An accepted event is held in an input register, its decision is evaluated
// from that register and the lifecycle state, and the result is registered
// in the result register, from which the result item is offered.
// Throughput: one event per cycle. The only feedback path is the lifecycle
// state update, which completes in the same cycle as the result register load.
// When the receiver stalls, the result register holds its item and the input
// register may still take one more event; req_bus.ready then drops until the
// result is taken.
// Reset (synchronous, active high) returns to power off with all flags,
// timestamps and the attempt count cleared and the registers at defaults.
module ecu_lifecycle_supervisor_top #(
   parameter int unsigned TIME_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   els_req_if.sink                                req_bus,
   els_rsp_if.source                              rsp_bus,
   input  logic                                   csr_we,
   input  logic [els_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [els_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int unsigned CW = (TIME_BITS > 32) ? TIME_BITS : 32;

   typedef enum logic [2:0] {
      MODE_OFF       = 3'd0,
      MODE_INIT      = 3'd1,
      MODE_SELF_TEST = 3'd2,
      MODE_STANDBY   = 3'd3,
      MODE_RUN       = 3'd4,
      MODE_FAULT     = 3'd5,
      MODE_RECOVERY  = 3'd6
   } mode_type;

   // Pipeline registers
   logic                  in_vld_ff;
   els_pkg::req_item_type in_item_ff;
   logic                  out_vld_ff;
   els_pkg::rsp_item_type rsp_ff;
   els_pkg::rsp_item_type rsp_in;

   // Lifecycle state
   mode_type              mode_ff, mode_in;
   logic [TIME_BITS-1:0]  since_ff, since_in;
   logic [TIME_BITS-1:0]  per_ff, per_in;
   logic                  power_ff, power_in;
   logic                  comm_ff, comm_in;
   logic                  latch_ff, latch_in;
   logic [15:0]           att_ff, att_in;

   // Timing registers
   logic [31:0]           pod_ff, cto_ff, rcd_ff, per_period_ff;

   logic                  advance;
   logic                  take_req;
   logic [TIME_BITS-1:0]  now_t;
   logic [TIME_BITS-1:0]  d_mode;
   logic [TIME_BITS-1:0]  d_per;
   logic [CW-1:0]         d_mode_x;
   logic [CW-1:0]         d_per_x;
   logic                  ge_pod, ge_cto, ge_rcd, ge_self, ge_settle, ge_per;
   logic                  enter;
   mode_type              enter_mode;
   logic                  fire, safe;

   // Handshake: the compute stage moves when the result slot is free or drained
   assign advance  = in_vld_ff && (!out_vld_ff || rsp_bus.ready);
   assign take_req = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !in_vld_ff || advance;

   assign rsp_bus.valid           = out_vld_ff;
   assign rsp_bus.mode            = rsp_ff.mode;
   assign rsp_bus.mode_changed    = rsp_ff.mode_changed;
   assign rsp_bus.periodic_fire   = rsp_ff.periodic_fire;
   assign rsp_bus.safe_outputs    = rsp_ff.safe_outputs;
   assign rsp_bus.comm_fault_flag = rsp_ff.comm_fault_flag;
   assign rsp_bus.latched_flag    = rsp_ff.latched_flag;
   assign rsp_bus.powered         = rsp_ff.powered;
   assign rsp_bus.attempts        = rsp_ff.attempts;

   // Elapsed times by wrapping subtraction
   assign now_t    = TIME_BITS'(in_item_ff.now_ms);
   assign d_mode   = now_t - since_ff;
   assign d_per    = now_t - per_ff;
   assign d_mode_x = CW'(d_mode);
   assign d_per_x  = CW'(d_per);

   assign ge_pod    = d_mode_x >= CW'(pod_ff);
   assign ge_cto    = d_mode_x >= CW'(cto_ff);
   assign ge_rcd    = d_mode_x >= CW'(rcd_ff);
   assign ge_self   = d_mode_x >= CW'(els_pkg::SELF_TEST_DWELL);
   assign ge_settle = d_mode_x >= CW'(els_pkg::SETTLE_DWELL);
   assign ge_per    = d_per_x >= CW'(per_period_ff);

   // Decide the transition for the held event
   always_comb begin
      enter      = 1'b0;
      enter_mode = mode_ff;
      power_in   = power_ff;
      comm_in    = comm_ff;
      latch_in   = latch_ff;
      att_in     = att_ff;
      per_in     = per_ff;
      fire       = 1'b0;
      safe       = 1'b0;
      case (in_item_ff.cmd)
         els_pkg::CMD_TICK: begin
            if (power_ff) begin
               unique case (mode_ff)
                  MODE_INIT: begin
                     if (ge_pod) begin
                        enter = 1'b1; enter_mode = MODE_SELF_TEST;
                     end
                  end
                  MODE_SELF_TEST: begin
                     if (ge_self) begin
                        enter = 1'b1; enter_mode = MODE_STANDBY;
                     end
                  end
                  MODE_STANDBY: begin
                     if (comm_ff) begin
                        if (ge_cto) begin
                           enter = 1'b1; enter_mode = MODE_FAULT;
                        end
                     end else if (ge_settle) begin
                        enter = 1'b1; enter_mode = MODE_RUN;
                     end
                  end
                  MODE_RUN: begin
                     if (comm_ff) begin
                        enter = 1'b1; enter_mode = MODE_FAULT;
                     end
                  end
                  MODE_FAULT: begin
                     if (!latch_ff && ge_rcd) begin
                        if (att_ff != els_pkg::ATTEMPT_MAX) att_in = att_ff + 16'd1;
                        enter = 1'b1; enter_mode = MODE_RECOVERY;
                     end
                  end
                  MODE_RECOVERY: begin
                     if (ge_settle) begin
                        enter = 1'b1; enter_mode = MODE_STANDBY;
                     end
                  end
                  default: ;
               endcase
               // Periodic and safe indications follow the mode after the move
               if (enter_mode == MODE_RUN && ge_per) begin
                  fire   = 1'b1;
                  per_in = now_t;
               end
               safe = (enter_mode == MODE_OFF) || (enter_mode == MODE_FAULT);
            end else begin
               safe = 1'b1;
            end
         end
         els_pkg::CMD_POWER_ON: begin
            if (!power_ff || mode_ff == MODE_OFF) begin
               power_in = 1'b1;
               comm_in  = 1'b0;
               latch_in = 1'b0;
               att_in   = '0;
               enter    = 1'b1; enter_mode = MODE_INIT;
            end
         end
         els_pkg::CMD_POWER_OFF: begin
            power_in = 1'b0;
            comm_in  = 1'b0;
            latch_in = 1'b0;
            att_in   = '0;
            enter    = 1'b1; enter_mode = MODE_OFF;
         end
         els_pkg::CMD_COMM: begin
            if (comm_ff != in_item_ff.fault_present) begin
               comm_in = in_item_ff.fault_present;
               if (in_item_ff.fault_present &&
                   (mode_ff == MODE_STANDBY || mode_ff == MODE_RUN)) begin
                  enter = 1'b1; enter_mode = MODE_FAULT;
               end else if (!in_item_ff.fault_present && mode_ff == MODE_FAULT &&
                            !latch_ff) begin
                  enter = 1'b1; enter_mode = MODE_RECOVERY;
               end
            end
         end
         els_pkg::CMD_LATCH: begin
            latch_in = 1'b1;
            enter    = 1'b1; enter_mode = MODE_FAULT;
         end
         els_pkg::CMD_CLEAR: begin
            comm_in  = 1'b0;
            latch_in = 1'b0;
            if (mode_ff == MODE_FAULT) begin
               enter = 1'b1; enter_mode = MODE_RECOVERY;
            end
         end
         els_pkg::CMD_RESET: begin
            power_in = 1'b1;
            comm_in  = 1'b0;
            latch_in = 1'b0;
            att_in   = '0;
            enter    = 1'b1; enter_mode = MODE_INIT;
         end
         default: ;
      endcase

      mode_in  = enter_mode;
      since_in = enter ? now_t : since_ff;

      rsp_in.mode            = mode_in;
      rsp_in.mode_changed    = enter;
      rsp_in.periodic_fire   = fire;
      rsp_in.safe_outputs    = safe;
      rsp_in.comm_fault_flag = comm_in;
      rsp_in.latched_flag    = latch_in;
      rsp_in.powered         = power_in;
      rsp_in.attempts        = att_in;
   end

   // Hold state, registers and the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff     <= 1'b0;
         out_vld_ff    <= 1'b0;
         mode_ff       <= MODE_OFF;
         since_ff      <= '0;
         per_ff        <= '0;
         power_ff      <= 1'b0;
         comm_ff       <= 1'b0;
         latch_ff      <= 1'b0;
         att_ff        <= '0;
         pod_ff        <= els_pkg::POWER_ON_DELAY_RST;
         cto_ff        <= els_pkg::COMM_TIMEOUT_RST;
         rcd_ff        <= els_pkg::RECOVERY_DELAY_RST;
         per_period_ff <= els_pkg::PERIODIC_PERIOD_RST;
      end else begin
         // Input stage
         if (take_req) begin
            in_vld_ff             <= 1'b1;
            in_item_ff.cmd           <= req_bus.cmd;
            in_item_ff.fault_present <= req_bus.fault_present;
            in_item_ff.now_ms        <= req_bus.now_ms;
         end else if (advance) begin
            in_vld_ff <= 1'b0;
         end

         // Commit state and load the result
         if (advance) begin
            mode_ff    <= mode_in;
            since_ff   <= since_in;
            per_ff     <= per_in;
            power_ff   <= power_in;
            comm_ff    <= comm_in;
            latch_ff   <= latch_in;
            att_ff     <= att_in;
            rsp_ff     <= rsp_in;
            out_vld_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_vld_ff <= 1'b0;
         end

         // Timing register writes
         if (csr_we) begin
            unique case (csr_index)
               els_pkg::CSR_POWER_ON_DELAY:  pod_ff        <= csr_wdata;
               els_pkg::CSR_COMM_TIMEOUT:    cto_ff        <= csr_wdata;
               els_pkg::CSR_RECOVERY_DELAY:  rcd_ff        <= csr_wdata;
               els_pkg::CSR_PERIODIC_PERIOD: per_period_ff <= csr_wdata;
            endcase
         end
      end
   end

   // Power off mode never coexists with a power request
   a_off_unpowered: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_OFF |-> !power_ff)
      else $error("power requested while in power off");

   // The periodic task only fires in run
   a_fire_in_run: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && rsp_ff.periodic_fire |-> rsp_ff.mode == MODE_RUN)
      else $error("periodic fire outside run");

   // Non-tick events never raise tick indications
   a_tick_only: assert property (@(posedge clock) disable iff (reset)
      advance && in_item_ff.cmd != els_pkg::CMD_TICK
      |=> !rsp_ff.periodic_fire && !rsp_ff.safe_outputs)
      else $error("tick indication on a non-tick event");

   // Attempts only drop on power on, power off or reset
   a_attempts_mono: assert property (@(posedge clock) disable iff (reset)
      advance && in_item_ff.cmd != els_pkg::CMD_POWER_ON &&
      in_item_ff.cmd != els_pkg::CMD_POWER_OFF && in_item_ff.cmd != els_pkg::CMD_RESET
      |=> att_ff >= $past(att_ff))
      else $error("attempt count decreased");

   // A mode change restamps the dwell timer
   a_restamp: assert property (@(posedge clock) disable iff (reset)
      advance && enter |=> since_ff == $past(now_t))
      else $error("dwell start not updated on mode change");

endmodule

// ===== test/tb_ecu_lifecycle_supervisor_top.sv =====
module tb_ecu_lifecycle_supervisor_top;

   // Lifecycle modes as reported in the mode field
   localparam logic [2:0] MODE_OFF       = 3'd0;
   localparam logic [2:0] MODE_INIT      = 3'd1;
   localparam logic [2:0] MODE_SELF_TEST = 3'd2;
   localparam logic [2:0] MODE_STANDBY   = 3'd3;
   localparam logic [2:0] MODE_RUN       = 3'd4;
   localparam logic [2:0] MODE_FAULT     = 3'd5;
   localparam logic [2:0] MODE_RECOVERY  = 3'd6;

   // Event code with no meaning: the block only reports its state
   localparam logic [2:0] CMD_UNUSED = 3'd7;

   localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;
   localparam int unsigned RANDOM_SETS = 6;
   localparam int unsigned ITEMS_PER_SET = 290;
   localparam int unsigned HOLD_CYCLES = 64;
   localparam int unsigned SPIN_TICKS = 60;

   typedef struct packed {
      els_pkg::req_item_type ev;
      logic                  fixed;
      els_pkg::rsp_item_type want;
   } script_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [els_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [els_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   els_req_if req_bus ();
   els_rsp_if rsp_bus ();

   ecu_lifecycle_supervisor_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Lifecycle state held by the predictor
   logic [2:0]  mode_q      = MODE_OFF;
   logic [31:0] since_q     = '0;
   logic [31:0] periodic_q  = '0;
   logic        pwr_q       = 1'b0;
   logic        comm_q      = 1'b0;
   logic        latch_q     = 1'b0;
   logic [15:0] att_q       = '0;
   logic        moved_q     = 1'b0;
   // Timing registers as last written
   logic [31:0] pod_q = els_pkg::POWER_ON_DELAY_RST;
   logic [31:0] ct_q  = els_pkg::COMM_TIMEOUT_RST;
   logic [31:0] rd_q  = els_pkg::RECOVERY_DELAY_RST;
   logic [31:0] pp_q  = els_pkg::PERIODIC_PERIOD_RST;

   els_pkg::rsp_item_type pending_status_q[$];
   script_row_type        script_q[$];
   logic [31:0]           wall_ms = '0;
   int unsigned           error_count = 0;
   int unsigned           send_idle_pct = 0;
   int unsigned           recv_idle_pct = 0;
   logic                  rsp_hold_req = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic els_pkg::rsp_item_type lc_status(input logic [2:0] mode,
                                                       input logic ch,
                                                       input logic fire, input logic safe,
                                                       input logic comm, input logic latch,
                                                       input logic pwr,
                                                       input logic [15:0] att);
      els_pkg::rsp_item_type s;
      s.mode            = mode;
      s.mode_changed    = ch;
      s.periodic_fire   = fire;
      s.safe_outputs    = safe;
      s.comm_fault_flag = comm;
      s.latched_flag    = latch;
      s.powered         = pwr;
      s.attempts        = att;
      return s;
   endfunction

   function automatic void enter_mode(input logic [2:0] m, input logic [31:0] now);
      mode_q  = m;
      since_q = now;
      moved_q = 1'b1;
   endfunction

   // Apply one event to the lifecycle state and return the status it reports
   function automatic els_pkg::rsp_item_type advance_lifecycle(
         input els_pkg::req_item_type ev);
      logic [31:0] dwell;
      logic [31:0] gap;
      logic        fire;
      logic        safe;
      dwell   = ev.now_ms - since_q;
      fire    = 1'b0;
      safe    = 1'b0;
      moved_q = 1'b0;
      case (ev.cmd)
         els_pkg::CMD_TICK: begin
            if (!pwr_q) begin
               safe = 1'b1;
            end else begin
               case (mode_q)
                  MODE_INIT: if (dwell >= pod_q) enter_mode(MODE_SELF_TEST, ev.now_ms);
                  MODE_SELF_TEST: begin
                     if (dwell >= els_pkg::SELF_TEST_DWELL)
                        enter_mode(MODE_STANDBY, ev.now_ms);
                  end
                  MODE_STANDBY: begin
                     if (comm_q) begin
                        if (dwell >= ct_q) enter_mode(MODE_FAULT, ev.now_ms);
                     end else if (dwell >= els_pkg::SETTLE_DWELL) begin
                        enter_mode(MODE_RUN, ev.now_ms);
                     end
                  end
                  MODE_RUN: if (comm_q) enter_mode(MODE_FAULT, ev.now_ms);
                  MODE_FAULT: begin
                     if (!latch_q && dwell >= rd_q) begin
                        if (att_q != els_pkg::ATTEMPT_MAX) att_q = att_q + 16'd1;
                        enter_mode(MODE_RECOVERY, ev.now_ms);
                     end
                  end
                  MODE_RECOVERY: begin
                     if (dwell >= els_pkg::SETTLE_DWELL) enter_mode(MODE_STANDBY, ev.now_ms);
                  end
                  default: ;
               endcase
               // periodic task runs on the post-transition mode
               gap = ev.now_ms - periodic_q;
               if (mode_q == MODE_RUN && gap >= pp_q) begin
                  fire       = 1'b1;
                  periodic_q = ev.now_ms;
               end
               if (mode_q == MODE_OFF || mode_q == MODE_FAULT) safe = 1'b1;
            end
         end
         els_pkg::CMD_POWER_ON: begin
            if (!(pwr_q && mode_q != MODE_OFF)) begin
               pwr_q   = 1'b1;
               comm_q  = 1'b0;
               latch_q = 1'b0;
               att_q   = '0;
               enter_mode(MODE_INIT, ev.now_ms);
            end
         end
         els_pkg::CMD_POWER_OFF: begin
            pwr_q   = 1'b0;
            comm_q  = 1'b0;
            latch_q = 1'b0;
            att_q   = '0;
            enter_mode(MODE_OFF, ev.now_ms);
         end
         els_pkg::CMD_COMM: begin
            if (comm_q != ev.fault_present) begin
               comm_q = ev.fault_present;
               if (ev.fault_present && (mode_q == MODE_STANDBY || mode_q == MODE_RUN))
                  enter_mode(MODE_FAULT, ev.now_ms);
               else if (!ev.fault_present && mode_q == MODE_FAULT && !latch_q)
                  enter_mode(MODE_RECOVERY, ev.now_ms);
            end
         end
         els_pkg::CMD_LATCH: begin
            latch_q = 1'b1;
            enter_mode(MODE_FAULT, ev.now_ms);
         end
         els_pkg::CMD_CLEAR: begin
            comm_q  = 1'b0;
            latch_q = 1'b0;
            if (mode_q == MODE_FAULT) enter_mode(MODE_RECOVERY, ev.now_ms);
         end
         els_pkg::CMD_RESET: begin
            comm_q  = 1'b0;
            latch_q = 1'b0;
            att_q   = '0;
            pwr_q   = 1'b1;
            enter_mode(MODE_INIT, ev.now_ms);
         end
         default: ;
      endcase
      return lc_status(mode_q, moved_q, fire, safe, comm_q, latch_q, pwr_q, att_q);
   endfunction

   // Draw a random event; time mostly moves forward, often landing on a dwell edge
   function automatic els_pkg::req_item_type pick_event();
      els_pkg::req_item_type ev;
      int unsigned  r;
      logic [31:0]  base;
      logic [31:0]  thr;
      ev.fault_present = 1'($urandom_range(1));
      r = $urandom_range(99);
      if (!pwr_q && r < 45) begin
         ev.cmd = els_pkg::CMD_POWER_ON;
      end else begin
         r = $urandom_range(99);
         if (r < 55)      ev.cmd = els_pkg::CMD_TICK;
         else if (r < 70) ev.cmd = els_pkg::CMD_COMM;
         else if (r < 77) ev.cmd = els_pkg::CMD_CLEAR;
         else if (r < 82) ev.cmd = els_pkg::CMD_LATCH;
         else if (r < 87) ev.cmd = els_pkg::CMD_POWER_ON;
         else if (r < 91) ev.cmd = els_pkg::CMD_POWER_OFF;
         else if (r < 97) ev.cmd = els_pkg::CMD_RESET;
         else             ev.cmd = CMD_UNUSED;
      end
      // a comm event usually toggles the flag
      if (ev.cmd == els_pkg::CMD_COMM)
         ev.fault_present = ($urandom_range(3) == 0) ? comm_q : !comm_q;
      base = since_q;
      case (mode_q)
         MODE_INIT:      thr = pod_q;
         MODE_SELF_TEST: thr = els_pkg::SELF_TEST_DWELL;
         MODE_STANDBY:   thr = comm_q ? ct_q : els_pkg::SETTLE_DWELL;
         MODE_RUN: begin
            base = periodic_q;
            thr  = pp_q;
         end
         MODE_FAULT:     thr = rd_q;
         MODE_RECOVERY:  thr = els_pkg::SETTLE_DWELL;
         default:        thr = '0;
      endcase
      r = $urandom_range(99);
      if (r < 12)      ev.now_ms = base + thr - 32'($urandom_range(1));
      else if (r < 80) ev.now_ms = wall_ms + 32'($urandom_range(40));
      else if (r < 95) ev.now_ms = wall_ms + 32'($urandom_range(600));
      else             ev.now_ms = $urandom();
      wall_ms = ev.now_ms;
      return ev;
   endfunction

   function automatic void add_row(input logic [2:0] cmd, input logic present,
                                   input logic [31:0] now, input logic fixed,
                                   input els_pkg::rsp_item_type want);
      script_row_type row;
      row.ev.cmd           = cmd;
      row.ev.fault_present = present;
      row.ev.now_ms        = now;
      row.fixed            = fixed;
      row.want             = want;
      script_q.push_back(row);
   endfunction

   // Report one mismatch on a single line and count it
   task automatic flag_error(input string msg);
      error_count++;
      $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want) flag_error($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // Offer one event, hold it until taken, then queue what it should report
   task automatic send_event(input els_pkg::req_item_type ev, input logic fixed,
                             input els_pkg::rsp_item_type want);
      els_pkg::rsp_item_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      @(negedge clock);
      req_bus.valid         = 1'b1;
      req_bus.cmd           = ev.cmd;
      req_bus.fault_present = ev.fault_present;
      req_bus.now_ms        = ev.now_ms;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = advance_lifecycle(ev);
      pending_status_q.push_back(fixed ? want : predicted);
   endtask

   task automatic send_random();
      send_event(pick_event(), 1'b0, '0);
   endtask

   // Stop offering and wait for every outstanding status
   task automatic await_idle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_status_q.size() != 0) @(posedge clock);
   endtask

   task automatic set_timing(input logic [els_pkg::CSR_INDEX_BITS-1:0] idx,
                             input logic [31:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         els_pkg::CSR_POWER_ON_DELAY:  pod_q = val;
         els_pkg::CSR_COMM_TIMEOUT:    ct_q  = val;
         els_pkg::CSR_RECOVERY_DELAY:  rd_q  = val;
         els_pkg::CSR_PERIODIC_PERIOD: pp_q  = val;
         default: ;
      endcase
   endtask

   task automatic set_all_timing(input logic [31:0] pod, input logic [31:0] ct,
                                 input logic [31:0] rd, input logic [31:0] pp);
      set_timing(els_pkg::CSR_POWER_ON_DELAY, pod);
      set_timing(els_pkg::CSR_COMM_TIMEOUT, ct);
      set_timing(els_pkg::CSR_RECOVERY_DELAY, rd);
      set_timing(els_pkg::CSR_PERIODIC_PERIOD, pp);
   endtask

   // Receiver: random back-pressure, or a long hold when asked
   initial begin
      int unsigned hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Check each status taken against the oldest expectation
   always @(posedge clock) begin : status_check
      els_pkg::rsp_item_type seen;
      els_pkg::rsp_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen = lc_status(rsp_bus.mode, rsp_bus.mode_changed, rsp_bus.periodic_fire,
                          rsp_bus.safe_outputs, rsp_bus.comm_fault_flag,
                          rsp_bus.latched_flag, rsp_bus.powered, rsp_bus.attempts);
         if (pending_status_q.size() == 0) begin
            flag_error("status item with nothing expected");
         end else begin
            want = pending_status_q.pop_front();
            compare_field("mode", 16'(seen.mode), 16'(want.mode));
            compare_field("mode_changed", 16'(seen.mode_changed), 16'(want.mode_changed));
            compare_field("periodic_fire", 16'(seen.periodic_fire), 16'(want.periodic_fire));
            compare_field("safe_outputs", 16'(seen.safe_outputs), 16'(want.safe_outputs));
            compare_field("comm_fault_flag", 16'(seen.comm_fault_flag),
                          16'(want.comm_fault_flag));
            compare_field("latched_flag", 16'(seen.latched_flag), 16'(want.latched_flag));
            compare_field("powered", 16'(seen.powered), 16'(want.powered));
            compare_field("attempts", seen.attempts, want.attempts);
         end
      end
   end

   initial begin
      int unsigned tail;
      int unsigned saved_idle;
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      req_bus.valid         = 1'b0;
      req_bus.cmd           = els_pkg::CMD_TICK;
      req_bus.fault_present = 1'b0;
      req_bus.now_ms        = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed walk through the lifecycle at default timing
      add_row(els_pkg::CMD_TICK, 1'b0, 32'd0, 1'b1,
              lc_status(MODE_OFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0));
      add_row(CMD_UNUSED, 1'b1, TIME_MAX, 1'b1,
              lc_status(MODE_OFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0));
      add_row(els_pkg::CMD_COMM, 1'b0, 32'd10, 1'b1,
              lc_status(MODE_OFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0));
      add_row(els_pkg::CMD_COMM, 1'b1, 32'd20, 1'b1,
              lc_status(MODE_OFF, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
      add_row(els_pkg::CMD_LATCH, 1'b0, 32'd30, 1'b1,
              lc_status(MODE_FAULT, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'd0));
      add_row(els_pkg::CMD_TICK, 1'b0, 32'd40, 1'b0, '0);
      add_row(els_pkg::CMD_POWER_ON, 1'b0, 32'd1000, 1'b1,
              lc_status(MODE_INIT, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0));
      add_row(els_pkg::CMD_POWER_ON, 1'b1, 32'd1001, 1'b1,
              lc_status(MODE_INIT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0));
      add_row(els_pkg::CMD_TICK, 1'b0, 32'd1099, 1'b0, '0);
      add_row(els_pkg::CMD_TICK, 1'b0, 32'd1100, 1'b0, '0);
      add_row(els_pkg::CMD_TICK, 1'b0, 32'd1160, 1'b0, '0);
      add_row(els_pkg::CMD_TICK, 1'b0, 32'd1260, 1'b0, '0);
      add_row(els_pkg::CMD_TICK, 1'b0, 32'd1269, 1'b0, '0);
      add_row(els_pkg::CMD_COMM, 1'b1, 32'd1270, 1'b0, '0);
      add_row(els_pkg::CMD_TICK, 1'b0, 32'd2270, 1'b0, '0);
      add_row(els_pkg::CMD_TICK, 1'b0, 32'd2370, 1'b0, '0);
      add_row(els_pkg::CMD_TICK, 1'b0, 32'd2869, 1'b0, '0);
      add_row(els_pkg::CMD_TICK, 1'b0, 32'd2870, 1'b0, '0);
      add_row(els_pkg::CMD_CLEAR, 1'b0, 32'd2900, 1'b0, '0);
      add_row(els_pkg::CMD_POWER_OFF, 1'b0, 32'd3000, 1'b1,
              lc_status(MODE_OFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0));
      add_row(els_pkg::CMD_POWER_OFF, 1'b1, 32'd3001, 1'b1,
              lc_status(MODE_OFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0));
      add_row(els_pkg::CMD_RESET, 1'b0, 32'hFFFF_FFF0, 1'b1,
              lc_status(MODE_INIT, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0));
      // wrapped dwell: 0x5F - 0xFFFFFFF0 is 111 ms
      add_row(els_pkg::CMD_TICK, 1'b0, 32'h0000_005F, 1'b0, '0);
      add_row(els_pkg::CMD_LATCH, 1'b1, 32'h0000_0060, 1'b1,
              lc_status(MODE_FAULT, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 16'd0));
      add_row(els_pkg::CMD_TICK, 1'b0, TIME_MAX, 1'b0, '0);

      send_idle_pct = 17;
      recv_idle_pct = 51;
      foreach (script_q[i]) send_event(script_q[i].ev, script_q[i].fixed, script_q[i].want);
      wall_ms = TIME_MAX;

      // Random phases, each under its own timing, with a back-pressure profile per pair
      for (int unsigned s = 0; s < RANDOM_SETS; s++) begin
         await_idle();
         case (s / 2)
            0: begin
               send_idle_pct = 17;
               recv_idle_pct = 51;
            end
            1: begin
               send_idle_pct = 51;
               recv_idle_pct = 17;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (s)
            1: set_all_timing('0, '0, '0, '0);
            3: set_all_timing(TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX);
            5: set_all_timing('0, TIME_MAX, 32'($urandom_range(1200)), TIME_MAX);
            default: set_all_timing(32'($urandom_range(150)), 32'($urandom_range(700)),
                                    32'($urandom_range(1200)), 32'($urandom_range(1, 30)));
         endcase
         saved_idle = send_idle_pct;
         for (int unsigned n = 0; n < ITEMS_PER_SET; n++) begin
            // hold the receiver off while events keep coming, to fill the pipe
            if (s == 1 && n == 100) begin
               rsp_hold_req  = 1'b1;
               send_idle_pct = 0;
            end
            if (s == 1 && n == 140) send_idle_pct = saved_idle;
            send_random();
         end
      end

      // Cycle fault, recovery and standby to grow the attempt count
      await_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_all_timing('0, '0, '0, 32'd1);
      send_event('{cmd: els_pkg::CMD_POWER_ON, fault_present: 1'b0, now_ms: wall_ms},
                 1'b0, '0);
      send_event('{cmd: els_pkg::CMD_COMM, fault_present: 1'b1, now_ms: wall_ms},
                 1'b0, '0);
      tail = 0;
      while (tail < SPIN_TICKS) begin
         wall_ms = wall_ms + els_pkg::SETTLE_DWELL;
         send_event('{cmd: els_pkg::CMD_TICK, fault_present: 1'b0, now_ms: wall_ms},
                    1'b0, '0);
         tail++;
      end

      await_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
